### hw/rtl/llir_pkg.sv
// ---------------------------------------------------------------------------
// llir_pkg: shared types and constants for the looping resampler
// Command codes, register indexes, channel structs and back-end state codes.
// ---------------------------------------------------------------------------
package llir_pkg;

   // command codes on req_data.cmd
   localparam logic [2:0] CMD_LOAD   = 3'd0;
   localparam logic [2:0] CMD_TICK   = 3'd1;
   localparam logic [2:0] CMD_PLAY   = 3'd2;
   localparam logic [2:0] CMD_PAUSE  = 3'd3;
   localparam logic [2:0] CMD_RESUME = 3'd4;
   localparam logic [2:0] CMD_STOP   = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [1:0] CSR_SRC_SCALE   = 2'd1;
   localparam logic [1:0] CSR_SPEED       = 2'd2;

   localparam int FC_W    = 17;
   localparam int RATE_W  = 19;
   localparam int SPEED_W = 18;
   localparam int CSR_W   = 19;

   localparam logic [RATE_W-1:0]  RATE_MAX    = 19'd262144;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 19'd65536;
   localparam logic [SPEED_W-1:0] SPEED_MIN   = 18'd21845;
   localparam logic [SPEED_W-1:0] SPEED_MAX   = 18'd196608;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 18'd65536;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_TICK,
      OP_PLAY,
      OP_PAUSE,
      OP_RESUME,
      OP_STOP
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP,
      ST_READ0,
      ST_READ1,
      ST_MUL,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [15:0]        load_addr;
      logic signed [15:0] load_left;
      logic signed [15:0] load_right;
      logic               play_loop;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               is_playing;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] addr;
      logic [15:0] left;
      logic [15:0] right;
      logic        play_loop;
   } entry_type;

   typedef struct packed {
      logic [FC_W-1:0]    frame_count;
      logic [RATE_W-1:0]  src_scale;
      logic [SPEED_W-1:0] speed;
   } cfg_type;

endpackage

### hw/rtl/llir_front.sv
// ---------------------------------------------------------------------------
// llir_front: command decode
// Classifies request beats, drops unused codes and out-of-range loads.
// ---------------------------------------------------------------------------
module llir_front
   import llir_pkg::*;
#(
   parameter int MAX_FRAMES = 65536
) (
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_data
);

   localparam int CMP_W = ($clog2(MAX_FRAMES + 1) > 16) ? $clog2(MAX_FRAMES + 1) : 17;

   logic addr_ok;
   logic keep;

   assign addr_ok = CMP_W'(req_data.load_addr) < CMP_W'(MAX_FRAMES);

   always_comb begin
      keep              = 1'b1;
      push_data.op      = OP_TICK;
      push_data.addr    = req_data.load_addr;
      push_data.left    = req_data.load_left;
      push_data.right   = req_data.load_right;
      push_data.play_loop = req_data.play_loop;
      unique case (req_data.cmd)
         CMD_LOAD: begin
            push_data.op = OP_LOAD;
            keep         = addr_ok;
         end
         CMD_TICK:   push_data.op = OP_TICK;
         CMD_PLAY:   push_data.op = OP_PLAY;
         CMD_PAUSE:  push_data.op = OP_PAUSE;
         CMD_RESUME: push_data.op = OP_RESUME;
         CMD_STOP:   push_data.op = OP_STOP;
         default:    keep = 1'b0;
      endcase
   end

   // dropped beats are still taken, they just never reach the queue
   assign push_valid = req_valid && keep;
   assign req_ready  = push_ready;

endmodule

### hw/rtl/llir_queue.sv
// ---------------------------------------------------------------------------
// llir_queue: two-entry command queue
// Decouples the decode front from the playback back end.
// ---------------------------------------------------------------------------
module llir_queue
   import llir_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_data
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### hw/rtl/llir_back.sv
// ---------------------------------------------------------------------------
// llir_back: playback engine
// Sample store, transport flags, read position, wrap remainder unit,
// two-tap interpolation and the result register.
// ---------------------------------------------------------------------------
module llir_back
   import llir_pkg::*;
#(
   parameter int MAX_FRAMES = 65536,
   parameter int FRAC_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_valid,
   output logic      q_ready,
   input  entry_type q_data,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int AW     = $clog2(MAX_FRAMES);
   localparam int IPW    = 18;
   localparam int POS_W  = FRAC_BITS + IPW;
   localparam int PROD_W = SPEED_W + RATE_W;
   localparam int NUM_W  = FRAC_BITS + 18;
   localparam int CNT_W  = $clog2(IPW);
   localparam int INC_SH = 32 - FRAC_BITS;
   localparam logic signed [NUM_W-1:0] BIAS =
      {{(NUM_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
   localparam logic signed [17:0] V_MAX = 18'sd32767;
   localparam logic signed [17:0] V_MIN = -18'sd32768;

   function automatic logic signed [15:0] lerp_out(input logic signed [15:0] a,
                                                   input logic signed [NUM_W-1:0] prod);
      logic signed [NUM_W-1:0] num;
      logic signed [NUM_W-1:0] adj;
      logic signed [17:0]      v;
      num = (NUM_W'(a) <<< FRAC_BITS) + prod;
      // truncate toward zero
      adj = num[NUM_W-1] ? (num + BIAS) : num;
      v   = adj[NUM_W-1:FRAC_BITS];
      if (v > V_MAX) begin
         return V_MAX[15:0];
      end else if (v < V_MIN) begin
         return V_MIN[15:0];
      end
      return v[15:0];
   endfunction

   state_type               state_ff, state_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    playing_ff, playing_in;
   logic                    paused_ff, paused_in;
   logic                    loop_ff, loop_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [FC_W-1:0]         rem_ff, rem_in;
   logic [IPW-1:0]          quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]           i1_ff, i1_in;
   logic [PROD_W-1:0]       inc_ff, inc_in;
   logic [31:0]             f0_ff, f0_in;
   logic signed [NUM_W-1:0] prod_l_ff, prod_l_in;
   logic signed [NUM_W-1:0] prod_r_ff, prod_r_in;

   logic [31:0]             mem [MAX_FRAMES];
   logic [31:0]             rdata_ff;
   logic                    rd_en, wr_en;
   logic [AW-1:0]           rd_addr, wr_addr;
   logic [31:0]             wr_data;

   logic [IPW-1:0]          ip;
   logic [FRAC_BITS-1:0]    frac;
   logic [IPW-1:0]          fc_w;
   logic                    at_end;
   logic [IPW:0]            ip_next;
   logic                    last;
   logic [IPW-1:0]          div_t, div_r;
   logic signed [16:0]      diff_l, diff_r;
   logic signed [FRAC_BITS:0] frac_s;

   assign ip      = pos_ff[POS_W-1:FRAC_BITS];
   assign frac    = pos_ff[FRAC_BITS-1:0];
   assign fc_w    = {1'b0, cfg.frame_count};
   assign at_end  = (ip >= fc_w);
   assign ip_next = {1'b0, ip} + 19'd1;
   assign last    = (ip_next >= {2'b00, cfg.frame_count});

   // one quotient bit per cycle of the wrap remainder
   assign div_t = {rem_ff, quo_ff[IPW-1]};
   assign div_r = (div_t >= fc_w) ? (div_t - fc_w) : div_t;

   assign frac_s = $signed({1'b0, frac});
   assign diff_l = $signed({rdata_ff[15], rdata_ff[15:0]})
                 - $signed({f0_ff[15], f0_ff[15:0]});
   assign diff_r = $signed({rdata_ff[31], rdata_ff[31:16]})
                 - $signed({f0_ff[31], f0_ff[31:16]});

   assign wr_addr = AW'(q_data.addr);
   assign wr_data = {q_data.right, q_data.left};

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      playing_in   = playing_ff;
      paused_in    = paused_ff;
      loop_in      = loop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      i1_in        = i1_ff;
      inc_in       = inc_ff;
      f0_in        = f0_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      q_ready      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = AW'(ip);
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // a tick waits until the result register is free
            if (q_valid && (q_data.op != OP_TICK || !rsp_valid_ff || rsp_ready)) begin
               q_ready = 1'b1;
               unique case (q_data.op)
                  OP_LOAD: wr_en = 1'b1;
                  OP_PLAY: begin
                     if (cfg.frame_count != '0) begin
                        loop_in    = q_data.play_loop;
                        playing_in = 1'b1;
                        paused_in  = 1'b0;
                     end
                  end
                  OP_PAUSE: paused_in = 1'b1;
                  OP_RESUME: begin
                     if (playing_ff) begin
                        paused_in = 1'b0;
                     end
                  end
                  OP_STOP: begin
                     playing_in = 1'b0;
                     paused_in  = 1'b0;
                     pos_in     = '0;
                  end
                  OP_TICK: begin
                     rsp_data_in.left_out   = '0;
                     rsp_data_in.right_out  = '0;
                     rsp_data_in.is_playing = playing_ff;
                     if (cfg.frame_count != '0 && playing_ff && !paused_ff) begin
                        if (at_end && !loop_ff) begin
                           // ran off the end: silence, stop
                           playing_in             = 1'b0;
                           rsp_data_in.is_playing = 1'b0;
                           rsp_valid_in           = 1'b1;
                        end else if (at_end) begin
                           rem_in   = '0;
                           quo_in   = ip;
                           cnt_in   = '0;
                           state_in = ST_WRAP;
                        end else begin
                           state_in = ST_READ0;
                        end
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WRAP: begin
            rem_in = div_r[FC_W-1:0];
            quo_in = {quo_ff[IPW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(IPW - 1)) begin
               pos_in   = {div_r, frac};
               state_in = ST_READ0;
            end
         end
         ST_READ0: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(ip);
            i1_in    = last ? (loop_ff ? '0 : AW'(ip)) : AW'(ip_next);
            inc_in   = cfg.speed * cfg.src_scale;
            state_in = ST_READ1;
         end
         ST_READ1: begin
            f0_in    = rdata_ff;
            rd_en    = 1'b1;
            rd_addr  = i1_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_l_in = frac_s * diff_l;
            prod_r_in = frac_s * diff_r;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            rsp_data_in.left_out   = lerp_out($signed(f0_ff[15:0]), prod_l_ff);
            rsp_data_in.right_out  = lerp_out($signed(f0_ff[31:16]), prod_r_ff);
            rsp_data_in.is_playing = playing_ff;
            rsp_valid_in           = 1'b1;
            pos_in                 = pos_ff + POS_W'(inc_ff >> INC_SH);
            state_in               = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         playing_ff   <= 1'b0;
         paused_ff    <= 1'b0;
         loop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         playing_ff   <= playing_in;
         paused_ff    <= paused_in;
         loop_ff      <= loop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      i1_ff       <= i1_in;
      inc_ff      <= inc_in;
      f0_ff       <= f0_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
   end

   // sample store: one write or one read per cycle, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_playing: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (playing_ff && !paused_ff))
      else $error("engine busy while not playing");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ0) |-> (ip < fc_w))
      else $error("read position past end of data");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !q_ready)
      else $error("queue popped while engine busy");

   a_result_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> !rsp_valid_ff)
      else $error("result register still full at interpolation");

   a_wrap_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRAP) |-> (rem_ff < cfg.frame_count))
      else $error("wrap remainder out of range");
`endif

endmodule

### hw/rtl/looping_linear_interp_resampler_core.sv
// ---------------------------------------------------------------------------
// looping_linear_interp_resampler_core: stereo linear-interpolation resampler
// Playing tick: accepted in idle, then read0, read1, mul, sum; a looping wrap
// adds the wrap state first. Ticks do not overlap (store read port shared by
// both taps); silent ticks and others end in idle, behind a 2-beat queue.
// Sync reset clears flags, state, position and config; store is not cleared.
// ---------------------------------------------------------------------------
module looping_linear_interp_resampler_core
   import llir_pkg::*;
#(
   parameter int MAX_FRAMES = 65536,
   parameter int FRAC_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int MFW   = $clog2(MAX_FRAMES + 1);
   localparam int SAT_W = (MFW > FC_W) ? MFW : FC_W;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready;
   entry_type push_data;
   logic      q_valid, q_ready;
   entry_type q_data;

   logic [FC_W-1:0]    wr_fc;
   logic [RATE_W-1:0]  wr_rate;
   logic [SPEED_W-1:0] wr_speed;

   assign wr_fc    = csr_wdata[FC_W-1:0];
   assign wr_rate  = csr_wdata[RATE_W-1:0];
   assign wr_speed = csr_wdata[SPEED_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_COUNT: begin
               cfg_in.frame_count = (SAT_W'(wr_fc) > SAT_W'(MAX_FRAMES))
                                  ? FC_W'(MAX_FRAMES) : wr_fc;
            end
            CSR_SRC_SCALE: begin
               cfg_in.src_scale = (wr_rate > RATE_MAX) ? RATE_MAX : wr_rate;
            end
            CSR_SPEED: begin
               if (wr_speed < SPEED_MIN) begin
                  cfg_in.speed = SPEED_MIN;
               end else if (wr_speed > SPEED_MAX) begin
                  cfg_in.speed = SPEED_MAX;
               end else begin
                  cfg_in.speed = wr_speed;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_count <= '0;
         cfg_ff.src_scale   <= RATE_RESET;
         cfg_ff.speed       <= SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   llir_front #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   llir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   llir_back #(
      .MAX_FRAMES (MAX_FRAMES),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
